[hdl/chacha_pkg.sv]
// Shared types and constants for the ChaCha20 stream cipher block.
`default_nettype none

package chacha_pkg;

   // Default number of double rounds (ChaCha20 proper).
   localparam int DOUBLE_ROUNDS_DEF = 10;

   // Widths of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_0     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_1     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_2     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_3     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NONCE_LO  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_NONCE_HI  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_START_CTR = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT     = 3'd7;

   // The four "expand 32-byte k" words.
   localparam logic [31:0] SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   // Step within a quarter round; each step is one add, xor and rotate.
   localparam logic [1:0] QR_STEP_ROT16 = 2'd0;
   localparam logic [1:0] QR_STEP_ROT12 = 2'd1;
   localparam logic [1:0] QR_STEP_ROT8  = 2'd2;
   localparam logic [1:0] QR_STEP_ROT7  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;   // copy the initial state into the working words
      logic       round;  // run one quarter-round step on all four lanes
      logic       diag;   // diagonal round when set, column round otherwise
      logic [1:0] step;   // quarter-round step
      logic       feed;   // add the initial state back, block becomes valid
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic blk_ready;    // keystream block is valid for the current counter
      logic cfg_wr;       // a valid configuration write in this cycle
   } sts_type;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ROUND = 3'b010,
      S_FEED  = 3'b100
   } state_type;

endpackage

`default_nettype wire

[hdl/chacha20_stream_cipher.sv]
// An accepted req beat appears as its rsp beat in the next cycle, from the output register.
// A keystream block is made in order: load, one add-xor-rotate step per
// cycle on four shared quarter-round lanes, then the feed-forward add.
// Each keystream block serves 64 bytes; no req beat is taken while the next block is made.
// Reset (synchronous, active high) clears key, nonce, counters and position; the first
// keystream block is computed straight after reset, before the first req beat is taken.
`default_nettype none

module chacha20_stream_cipher
   import chacha_pkg::*;
#(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   // Input stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] data_byte
   input  wire logic                   req_tlast,
   // Result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_byte
   output logic                        rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   chacha_ctrl #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   chacha_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // No beat is taken while the block generator is busy.
   a_no_beat_while_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(cmd.load || cmd.round || cmd.feed))
      else $error("req beat accepted during keystream generation");

   // Every accepted beat shows up in the output register on the next cycle.
   a_beat_reaches_output : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted req beat did not reach the output register");

   // A feed-forward add without a configuration write leaves a valid block.
   a_feed_sets_ready : assert property (@(posedge clock) disable iff (reset)
      (cmd.feed && !sts.cfg_wr) |=> sts.blk_ready)
      else $error("keystream block not valid after feed-forward");

   // A configuration write invalidates the keystream block.
   a_cfg_restarts : assert property (@(posedge clock) disable iff (reset)
      sts.cfg_wr |=> !req_tready)
      else $error("req ready straight after a configuration write");
`endif

endmodule

`default_nettype wire

[hdl/chacha_ctrl.sv]
// Controller state machine that sequences keystream block generation.
`default_nettype none

module chacha_ctrl
   import chacha_pkg::*;
#(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam int TOTAL_STEPS = DOUBLE_ROUNDS * 8;
   localparam int STEP_W      = $clog2(TOTAL_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   // Next state and commands. A configuration write abandons any block in flight.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.step  = cnt_ff[1:0];
      cmd.diag  = cnt_ff[2];
      case (state_ff)
         S_IDLE: begin
            if (!sts.cfg_wr && !sts.blk_ready) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_FEED;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FEED: begin
            cmd.feed = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (sts.cfg_wr) begin
         state_in = S_IDLE;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[hdl/chacha_dp.sv]
// Datapath: configuration, four quarter-round lanes, keystream and byte stream.
`default_nettype none

module chacha_dp
   import chacha_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);

   logic [31:0] key_ff   [8];
   logic [31:0] key_in   [8];
   logic [31:0] nonce_ff [3];
   logic [31:0] nonce_in [3];
   logic [31:0] start_ff, start_in;
   logic [31:0] ctr_ff, ctr_in;
   logic [5:0]  pos_ff, pos_in;
   logic        ready_ff, ready_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] w_ff     [16];
   logic [31:0] w_in     [16];
   logic [31:0] w_round  [16];
   logic [31:0] init_w   [16];
   logic        cfg_wr;
   logic        byte_acc;
   logic [31:0] ks_word;
   logic [7:0]  ks_byte;

   // Rotate left by the amount that belongs to the quarter-round step.
   function automatic logic [31:0] qr_rotl(input logic [31:0] v, input logic [1:0] step);
      logic [31:0] r;
      case (step)
         QR_STEP_ROT16: r = {v[15:0], v[31:16]};
         QR_STEP_ROT12: r = {v[19:0], v[31:20]};
         QR_STEP_ROT8:  r = {v[23:0], v[31:24]};
         QR_STEP_ROT7:  r = {v[24:0], v[31:25]};
         default:       r = v;
      endcase
      return r;
   endfunction

   assign csr_ready  = 1'b1;
   assign cfg_wr     = csr_valid && (csr_index < REG_COUNT);
   assign req_tready = ready_ff && (!rsp_valid_ff || rsp_tready);
   assign byte_acc   = req_tvalid && req_tready;

   assign sts.blk_ready = ready_ff;
   assign sts.cfg_wr    = cfg_wr;

   // Configuration register writes; the 32-bit registers keep the low half.
   always_comb begin
      key_in   = key_ff;
      nonce_in = nonce_ff;
      start_in = start_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_KEY_0: begin
               key_in[0] = csr_data[31:0];
               key_in[1] = csr_data[63:32];
            end
            REG_KEY_1: begin
               key_in[2] = csr_data[31:0];
               key_in[3] = csr_data[63:32];
            end
            REG_KEY_2: begin
               key_in[4] = csr_data[31:0];
               key_in[5] = csr_data[63:32];
            end
            REG_KEY_3: begin
               key_in[6] = csr_data[31:0];
               key_in[7] = csr_data[63:32];
            end
            REG_NONCE_LO: begin
               nonce_in[0] = csr_data[31:0];
               nonce_in[1] = csr_data[63:32];
            end
            REG_NONCE_HI: begin
               nonce_in[2] = csr_data[31:0];
            end
            REG_START_CTR: begin
               start_in = csr_data[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Initial cipher state: constants, key, block counter, nonce.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_w[i] = SIGMA[i];
      end
      for (int i = 0; i < 8; i++) begin
         init_w[4 + i] = key_ff[i];
      end
      init_w[12] = ctr_ff;
      for (int i = 0; i < 3; i++) begin
         init_w[13 + i] = nonce_ff[i];
      end
   end

   // One quarter-round step on the four independent lanes. Even steps update
   // a and d, odd steps update c and b.
   always_comb begin
      logic [1:0]  lb, lc, ld;
      logic [3:0]  ia, ib, ic, id;
      logic [31:0] sum;
      w_round = w_ff;
      for (int l = 0; l < 4; l++) begin
         lb  = cmd.diag ? 2'(l + 1) : 2'(l);
         lc  = cmd.diag ? 2'(l + 2) : 2'(l);
         ld  = cmd.diag ? 2'(l + 3) : 2'(l);
         ia  = {2'b00, 2'(l)};
         ib  = {2'b01, lb};
         ic  = {2'b10, lc};
         id  = {2'b11, ld};
         if (!cmd.step[0]) begin
            sum          = w_ff[ia] + w_ff[ib];
            w_round[ia]  = sum;
            w_round[id]  = qr_rotl(w_ff[id] ^ sum, cmd.step);
         end else begin
            sum          = w_ff[ic] + w_ff[id];
            w_round[ic]  = sum;
            w_round[ib]  = qr_rotl(w_ff[ib] ^ sum, cmd.step);
         end
      end
   end

   // Working words: load, round step or feed-forward add.
   always_comb begin
      w_in = w_ff;
      if (cmd.load) begin
         w_in = init_w;
      end else if (cmd.round) begin
         w_in = w_round;
      end else if (cmd.feed) begin
         for (int i = 0; i < 16; i++) begin
            w_in[i] = w_ff[i] + init_w[i];
         end
      end
   end

   // Keystream byte at the current position, little-endian within each word.
   assign ks_word = w_ff[pos_ff[5:2]];
   assign ks_byte = ks_word[{pos_ff[1:0], 3'b000} +: 8];

   // Position, counter and block-valid flag. A configuration write or a
   // last beat restarts the message at the configured counter.
   always_comb begin
      pos_in   = pos_ff;
      ctr_in   = ctr_ff;
      ready_in = ready_ff;
      if (cfg_wr) begin
         pos_in   = '0;
         ctr_in   = start_in;
         ready_in = 1'b0;
      end else if (byte_acc) begin
         if (req_tlast) begin
            pos_in   = '0;
            ctr_in   = start_ff;
            ready_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == 6'h3f) begin
               ctr_in   = ctr_ff + 1'b1;
               ready_in = 1'b0;
            end
         end
      end else if (cmd.feed) begin
         ready_in = 1'b1;
      end
   end

   // Output register; a new beat may enter as the held one leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (byte_acc) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = req_tdata ^ ks_byte;
         rsp_last_in  = req_tlast;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            key_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            nonce_ff[i] <= '0;
         end
         start_ff     <= '0;
         ctr_ff       <= '0;
         pos_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         nonce_ff     <= nonce_in;
         start_ff     <= start_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire
